[rtl/core/point_in_shape_test_core_macros.svh]
// Assertion macros shared by the point-in-shape test core.
`ifndef POINT_IN_SHAPE_TEST_CORE_MACROS_SVH
`define POINT_IN_SHAPE_TEST_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/pis_pkg.sv]
// Shared types and constants of the point-in-shape test core.
`timescale 1ns / 1ps

package pis_pkg;

   localparam int LEN_BITS      = 31;
   localparam int LEN_SQ_BITS   = 2 * LEN_BITS;
   localparam int COS_BITS      = 18;
   localparam int COS_MAG_BITS  = COS_BITS - 1;
   localparam int COS_SQ_BITS   = 2 * (COS_BITS - 2) + 1;
   localparam int COS_SQ_SHIFT  = 2 * (COS_BITS - 2);
   localparam int KIND_BITS     = 3;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = LEN_BITS;

   localparam logic [KIND_BITS-1:0] KIND_SPHERE  = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_CAPSULE = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_BOX     = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_SECTOR  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_RING    = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_LINE    = 3'd5;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_KIND   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RADIUS = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_INNER  = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EXT_X  = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EXT_Y  = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EXT_Z  = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COS    = 3'd6;

   localparam logic signed [COS_BITS-1:0] COS_ONE       = 18'sd65536;
   localparam logic signed [COS_BITS-1:0] COS_MINUS_ONE = -18'sd65536;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [LEN_BITS-1:0]  radius;
      logic [LEN_BITS-1:0]  inner;
      logic [LEN_BITS-1:0]  ext_x;
      logic [LEN_BITS-1:0]  ext_y;
      logic [LEN_BITS-1:0]  ext_z;
      logic [COS_BITS-1:0]  cos_half;
   } cfg_type;

   typedef struct packed {
      logic                   shape_ok;
      logic [LEN_SQ_BITS-1:0] radius_sq;
      logic [LEN_SQ_BITS-1:0] inner_sq;
      logic [COS_SQ_BITS-1:0] cos_sq;
   } cfg_derived_type;

endpackage

[rtl/core/pis_req_if.sv]
// Request channel: one point per transfer.
`timescale 1ns / 1ps

interface pis_req_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;

   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

[rtl/core/pis_rsp_if.sv]
// Response channel: one containment result per transfer.
`timescale 1ns / 1ps

interface pis_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic shape_ok;

   modport source (output valid, inside_res, shape_ok, input ready);
   modport sink (input valid, inside_res, shape_ok, output ready);
endinterface

[rtl/core/pis_mul.sv]
// Two-stage unsigned multiplier built from sliced partial products.
`timescale 1ns / 1ps

module pis_mul #(
   parameter int A_BITS     = 32,
   parameter int B_BITS     = 32,
   parameter int SLICE_BITS = 24
) (
   input  logic                     clock,
   input  logic                     en_part,
   input  logic                     en_sum,
   input  logic [A_BITS-1:0]        a,
   input  logic [B_BITS-1:0]        b,
   output logic [A_BITS+B_BITS-1:0] prod
);

   localparam int NUM_SLICES = (A_BITS + SLICE_BITS - 1) / SLICE_BITS;
   localparam int PAD_BITS   = NUM_SLICES * SLICE_BITS;
   localparam int PP_BITS    = SLICE_BITS + B_BITS;
   localparam int P_BITS     = A_BITS + B_BITS;

   logic [PAD_BITS-1:0] a_pad;
   logic [PP_BITS-1:0]  part_ff [NUM_SLICES];
   logic [P_BITS-1:0]   prod_ff;
   logic [P_BITS-1:0]   prod_in;

   assign a_pad = PAD_BITS'(a);

   // slice products first, weighted sum one stage later
   always_ff @(posedge clock) begin
      if (en_part) begin
         for (int j = 0; j < NUM_SLICES; j++) begin
            part_ff[j] <= PP_BITS'(a_pad[j*SLICE_BITS +: SLICE_BITS]) * PP_BITS'(b);
         end
      end
      if (en_sum) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      prod_in = '0;
      for (int j = 0; j < NUM_SLICES; j++) begin
         prod_in = prod_in + (P_BITS'(part_ff[j]) << (j * SLICE_BITS));
      end
   end

   assign prod = prod_ff;

endmodule

[rtl/core/pis_cfg.sv]
// Configuration registers and the values derived from them.
`timescale 1ns / 1ps

module pis_cfg import pis_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg,
   output cfg_derived_type          der
);

   cfg_type                 cfg_ff;
   cfg_derived_type         der_ff;
   cfg_derived_type         der_in;
   logic                    cos_in_range;
   logic [COS_BITS-1:0]     cos_abs;
   logic [2*COS_MAG_BITS-1:0] cos_prod;
   logic [LEN_SQ_BITS-1:0]  radius_prod;
   logic [LEN_SQ_BITS-1:0]  inner_prod;

   always_comb begin
      cos_in_range = ($signed(cfg_ff.cos_half) >= COS_MINUS_ONE) &&
                     ($signed(cfg_ff.cos_half) < COS_ONE);
      cos_abs      = cfg_ff.cos_half[COS_BITS-1] ? (~cfg_ff.cos_half + 1'b1) : cfg_ff.cos_half;
      cos_prod     = (2 * COS_MAG_BITS)'(cos_abs[COS_MAG_BITS-1:0]) *
                     (2 * COS_MAG_BITS)'(cos_abs[COS_MAG_BITS-1:0]);
      radius_prod  = LEN_SQ_BITS'(cfg_ff.radius) * LEN_SQ_BITS'(cfg_ff.radius);
      inner_prod   = LEN_SQ_BITS'(cfg_ff.inner) * LEN_SQ_BITS'(cfg_ff.inner);

      der_in.radius_sq = radius_prod;
      der_in.inner_sq  = inner_prod;
      der_in.cos_sq    = cos_prod[COS_SQ_BITS-1:0];

      case (cfg_ff.kind)
         KIND_SPHERE:  der_in.shape_ok = (cfg_ff.radius != '0);
         KIND_CAPSULE: der_in.shape_ok = (cfg_ff.radius != '0) &&
                                         (cfg_ff.ext_z >= cfg_ff.radius);
         KIND_BOX:     der_in.shape_ok = (cfg_ff.ext_x != '0) && (cfg_ff.ext_y != '0) &&
                                         (cfg_ff.ext_z != '0);
         KIND_SECTOR:  der_in.shape_ok = (cfg_ff.radius != '0) && cos_in_range;
         KIND_RING:    der_in.shape_ok = (cfg_ff.radius != '0) && (cfg_ff.inner != '0) &&
                                         (cfg_ff.inner < cfg_ff.radius) && cos_in_range;
         KIND_LINE:    der_in.shape_ok = (cfg_ff.ext_x != '0) && (cfg_ff.radius != '0);
         default:      der_in.shape_ok = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind     <= KIND_SPHERE;
         cfg_ff.radius   <= '0;
         cfg_ff.inner    <= '0;
         cfg_ff.ext_x    <= '0;
         cfg_ff.ext_y    <= '0;
         cfg_ff.ext_z    <= '0;
         cfg_ff.cos_half <= COS_MINUS_ONE;
         der_ff          <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KIND:   cfg_ff.kind     <= csr_wdata[KIND_BITS-1:0];
               CSR_RADIUS: cfg_ff.radius   <= csr_wdata;
               CSR_INNER:  cfg_ff.inner    <= csr_wdata;
               CSR_EXT_X:  cfg_ff.ext_x    <= csr_wdata;
               CSR_EXT_Y:  cfg_ff.ext_y    <= csr_wdata;
               CSR_EXT_Z:  cfg_ff.ext_z    <= csr_wdata;
               CSR_COS:    cfg_ff.cos_half <= csr_wdata[COS_BITS-1:0];
               default:    ;
            endcase
         end
         der_ff <= der_in;
      end
   end

   assign cfg = cfg_ff;
   assign der = der_ff;

endmodule

[rtl/core/pis_ctrl.sv]
// Valid bits and per-stage load enables of the pipeline.
`timescale 1ns / 1ps

module pis_ctrl #(parameter int NUM_STAGES = 8) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  out_ready,
   output logic                  in_ready,
   output logic                  out_valid,
   output logic [NUM_STAGES-1:0] stage_en,
   output logic [NUM_STAGES-1:0] stage_valid
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] shifted;

   // a stage loads when it is empty or its item moves on
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      shifted  = {valid_ff[NUM_STAGES-2:0], in_valid};
      valid_in = (stage_en & shifted) | (~stage_en & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready    = stage_en[0];
   assign out_valid   = valid_ff[NUM_STAGES-1];
   assign stage_valid = valid_ff;

endmodule

[rtl/core/point_in_shape_test_core.sv]
// Point-in-shape test core: tests one local-frame point against the configured shape.
// Each point passes the registers of stages 0 to 7 in order before its result is offered.
// Throughput: one point per cycle while results are taken, through the eight-register pipeline.
// Each stage holds its item while the next one is full, so stalls lose nothing.
// Reset (synchronous, active high) empties the pipeline and loads register defaults.
`timescale 1ns / 1ps

`include "point_in_shape_test_core_macros.svh"

module point_in_shape_test_core import pis_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   pis_req_if.sink                  req_if,
   pis_rsp_if.source                rsp_if,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // Widths of the intermediate values
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int D2_BITS    = SQ_BITS + 1;
   localparam int S3_BITS    = SQ_BITS + 2;
   localparam int CMP_BITS   = (S3_BITS > LEN_SQ_BITS) ? S3_BITS : LEN_SQ_BITS;
   localparam int PROD_BITS  = D2_BITS + COS_SQ_BITS;
   localparam int MIX_BITS   = ((COORD_BITS > LEN_BITS) ? COORD_BITS : LEN_BITS) + 1;
   localparam int NUM_STAGES = 8;

   typedef struct packed {
      logic box_in;
      logic z_in;
      logic on_axis;
      logic neg_x;
   } flags_type;

   typedef struct packed {
      logic sum_le;
      logic d2_le;
      logic inner_le;
   } cmp_type;

   cfg_type                 cfg;
   cfg_derived_type         der;
   logic [NUM_STAGES-1:0]   stage_en;
   logic [NUM_STAGES-1:0]   stage_valid;

   // stage 0: magnitudes
   logic [COORD_BITS-1:0]   ax_ff, ay_ff, az_ff;
   logic [COORD_BITS-1:0]   ax_in, ay_in, az_in;
   logic                    nx_ff, nx_in;

   // stage 1: operands of the three squares
   logic [LEN_BITS-1:0]     seg;
   logic [MIX_BITS-1:0]     ax_w, ay_w, az_w, seg_w, ex_w, ey_w, ez_w;
   logic [MIX_BITS-1:0]     dz_w, dx_w;
   logic [COORD_BITS-1:0]   q0_ff, q1_ff, q2_ff;
   logic [COORD_BITS-1:0]   q0_in, q1_in, q2_in;
   flags_type               flags_in;
   flags_type               flags_ff [1:6];

   // stages 2 and 3: squares
   logic [SQ_BITS-1:0]      sq0, sq1, sq2;

   // stage 4: sums of squares
   logic [D2_BITS-1:0]      d2_ff, d2_in;
   logic [S3_BITS-1:0]      s3_ff, s3_in;
   logic [SQ_BITS-1:0]      lhs4_ff, lhs5_ff, lhs6_ff;

   // stages 5 and 6: radius compares and the scaled planar distance
   cmp_type                 cmp_in;
   cmp_type                 cmp5_ff, cmp6_ff;
   logic [PROD_BITS-1:0]    rhs;

   // stage 7: result register
   logic [PROD_BITS-1:0]    lhs_w;
   logic                    base_in, angle_in, hit_in;
   logic                    inside_ff, inside_in;
   logic                    ok_ff, ok_in;

   function automatic logic [COORD_BITS-1:0] mag(input logic [COORD_BITS-1:0] raw);
      return raw[COORD_BITS-1] ? (~raw + 1'b1) : raw;
   endfunction

   pis_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .der       (der)
   );

   pis_ctrl #(.NUM_STAGES(NUM_STAGES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_if.valid),
      .out_ready   (rsp_if.ready),
      .in_ready    (req_if.ready),
      .out_valid   (rsp_if.valid),
      .stage_en    (stage_en),
      .stage_valid (stage_valid)
   );

   // Stage 0: take the point, fold each coordinate to sign and magnitude.
   always_comb begin
      ax_in = mag(req_if.point_x);
      ay_in = mag(req_if.point_y);
      az_in = mag(req_if.point_z);
      nx_in = req_if.point_x[COORD_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         az_ff <= az_in;
         nx_ff <= nx_in;
      end
   end

   // Stage 1: clamp to the capsule segment or the sweep line, do the box and
   // height tests, and pick the three values whose squares are needed.
   always_comb begin
      seg   = cfg.ext_z - cfg.radius;
      ax_w  = MIX_BITS'(ax_ff);
      ay_w  = MIX_BITS'(ay_ff);
      az_w  = MIX_BITS'(az_ff);
      seg_w = MIX_BITS'(seg);
      ex_w  = MIX_BITS'(cfg.ext_x);
      ey_w  = MIX_BITS'(cfg.ext_y);
      ez_w  = MIX_BITS'(cfg.ext_z);

      // distance beyond the capsule's straight part
      dz_w = (az_w > seg_w) ? (az_w - seg_w) : '0;
      // behind the origin the sweep measures from 0, ahead of it from extent_x
      if (nx_ff) begin
         dx_w = ax_w;
      end else begin
         dx_w = (ax_w > ex_w) ? (ax_w - ex_w) : '0;
      end

      flags_in.box_in  = (ax_w <= ex_w) && (ay_w <= ey_w) && (az_w <= ez_w);
      flags_in.z_in    = (az_w <= ez_w);
      flags_in.on_axis = (ax_ff == '0) && (ay_ff == '0);
      flags_in.neg_x   = nx_ff;

      q0_in = ax_ff;
      q1_in = ay_ff;
      q2_in = az_ff;
      case (cfg.kind)
         KIND_CAPSULE: q2_in = dz_w[COORD_BITS-1:0];
         KIND_LINE:    q0_in = dx_w[COORD_BITS-1:0];
         default:      ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         q0_ff       <= q0_in;
         q1_ff       <= q1_in;
         q2_ff       <= q2_in;
         flags_ff[1] <= flags_in;
      end
   end

   // Flags ride along with the item to the result stage.
   always_ff @(posedge clock) begin
      for (int i = 2; i <= 6; i++) begin
         if (stage_en[i]) begin
            flags_ff[i] <= flags_ff[i-1];
         end
      end
   end

   // Stages 2 and 3: squares, partial products then their sum.
   pis_mul #(.A_BITS(COORD_BITS), .B_BITS(COORD_BITS)) u_sq0 (
      .clock   (clock),
      .en_part (stage_en[2]),
      .en_sum  (stage_en[3]),
      .a       (q0_ff),
      .b       (q0_ff),
      .prod    (sq0)
   );

   pis_mul #(.A_BITS(COORD_BITS), .B_BITS(COORD_BITS)) u_sq1 (
      .clock   (clock),
      .en_part (stage_en[2]),
      .en_sum  (stage_en[3]),
      .a       (q1_ff),
      .b       (q1_ff),
      .prod    (sq1)
   );

   pis_mul #(.A_BITS(COORD_BITS), .B_BITS(COORD_BITS)) u_sq2 (
      .clock   (clock),
      .en_part (stage_en[2]),
      .en_sum  (stage_en[3]),
      .a       (q2_ff),
      .b       (q2_ff),
      .prod    (sq2)
   );

   // Stage 4: planar distance squared and full distance squared.
   always_comb begin
      d2_in = D2_BITS'(sq0) + D2_BITS'(sq1);
      s3_in = S3_BITS'(d2_in) + S3_BITS'(sq2);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         d2_ff   <= d2_in;
         s3_ff   <= s3_in;
         lhs4_ff <= sq0;
      end
   end

   // Stage 5: radius compares; start scaling the planar distance by cos^2.
   always_comb begin
      cmp_in.sum_le   = CMP_BITS'(s3_ff) <= CMP_BITS'(der.radius_sq);
      cmp_in.d2_le    = CMP_BITS'(d2_ff) <= CMP_BITS'(der.radius_sq);
      cmp_in.inner_le = CMP_BITS'(der.inner_sq) <= CMP_BITS'(d2_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         cmp5_ff <= cmp_in;
         lhs5_ff <= lhs4_ff;
      end
      if (stage_en[6]) begin
         cmp6_ff <= cmp5_ff;
         lhs6_ff <= lhs5_ff;
      end
   end

   pis_mul #(.A_BITS(D2_BITS), .B_BITS(COS_SQ_BITS)) u_cos_scale (
      .clock   (clock),
      .en_part (stage_en[5]),
      .en_sum  (stage_en[6]),
      .a       (d2_ff),
      .b       (der.cos_sq),
      .prod    (rhs)
   );

   // Stage 7: angle test and final answer. The angle test compares
   // x^2 * one^2 against (x^2 + y^2) * cos^2 instead of taking a root.
   always_comb begin
      lhs_w   = PROD_BITS'(lhs6_ff) << COS_SQ_SHIFT;
      base_in = flags_ff[6].z_in && cmp6_ff.d2_le &&
                ((cfg.kind != KIND_RING) || cmp6_ff.inner_le);

      if (cfg.cos_half == COS_MINUS_ONE) begin
         // full circle
         angle_in = 1'b1;
      end else if (flags_ff[6].on_axis) begin
         // point on the axis: sector keeps it, ring sector drops it
         angle_in = (cfg.kind == KIND_SECTOR);
      end else if (!cfg.cos_half[COS_BITS-1]) begin
         angle_in = !flags_ff[6].neg_x && (rhs <= lhs_w);
      end else begin
         angle_in = !flags_ff[6].neg_x || (lhs_w <= rhs);
      end

      case (cfg.kind)
         KIND_SPHERE, KIND_CAPSULE, KIND_LINE: hit_in = cmp6_ff.sum_le;
         KIND_BOX:                             hit_in = flags_ff[6].box_in;
         KIND_SECTOR, KIND_RING:               hit_in = base_in && angle_in;
         default:                              hit_in = 1'b0;
      endcase

      // an invalid shape always answers outside
      ok_in     = der.shape_ok;
      inside_in = der.shape_ok && hit_in;
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         inside_ff <= inside_in;
         ok_ff     <= ok_in;
      end
   end

   assign rsp_if.inside_res = inside_ff;
   assign rsp_if.shape_ok   = ok_ff;

   // Checks
   `PIS_ASSERT_NOW(a_inside_needs_ok, clock, reset, rsp_if.valid && rsp_if.inside_res, rsp_if.shape_ok, "inside reported for an invalid shape")
   `PIS_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_if.ready, (&stage_valid) && !rsp_if.ready, "request held off with an empty stage")
   `PIS_ASSERT_NEXT(a_unknown_kind_invalid, clock, reset, cfg.kind > KIND_LINE, !der.shape_ok, "unknown shape kind marked valid")

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the point-in-shape test core with random points and shapes.
`timescale 1ns / 1ps

module tb_top;
   import pis_pkg::*;

   localparam int COORD_BITS   = 32;
   localparam int UNIT         = 65536;          // 1.0 in Q16.16
   localparam int TOTAL_POINTS = 775;            // directed part plus about 750 random
   localparam int END_CYCLES   = 16;             // allow margin for the pipeline to drain
   localparam logic [LEN_BITS-1:0] MAX_LEN = '1;
   localparam logic signed [COORD_BITS-1:0] MIN_COORD = 32'sh8000_0000;
   localparam logic signed [COORD_BITS-1:0] MAX_COORD = 32'sh7FFF_FFFF;
   // Kind codes that name no shape.
   localparam logic [KIND_BITS-1:0] KIND_BAD_LO = 3'd6;
   localparam logic [KIND_BITS-1:0] KIND_BAD_HI = 3'd7;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   typedef struct packed {
      logic inside_res;
      logic shape_ok;
   } verdict_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   pis_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
   pis_rsp_if rsp_ch ();

   point_in_shape_test_core #(.COORD_BITS(COORD_BITS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shape as the core holds it; changed only while the core is empty.
   cfg_type     shape;
   point_type   pending_points[$];
   verdict_type expected_verdicts[$];
   int          points_queued;
   int          fault_count;
   int          send_gap;
   int          ready_gap;
   bit          steady_phase;       // no idling on either side for this phase

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction: exact integer containment test on wide intermediates.
   // ---------------------------------------------------------------------
   function automatic verdict_type judge_point(point_type p);
      logic [31:0]        ax, ay, az, seg, dz, dx;
      logic [65:0]        ax2, ay2, az2, d2, r2, in2;
      logic [99:0]        lhs, rhs;
      logic signed [17:0] c;
      longint             ci, cmag;
      logic               cos_ok;
      verdict_type        v;
      c   = shape.cos_half;
      ci  = longint'(c);
      ax  = p.x[31] ? ~p.x + 32'd1 : p.x;
      ay  = p.y[31] ? ~p.y + 32'd1 : p.y;
      az  = p.z[31] ? ~p.z + 32'd1 : p.z;
      ax2 = 66'(ax) * 66'(ax);
      ay2 = 66'(ay) * 66'(ay);
      az2 = 66'(az) * 66'(az);
      r2  = 66'(shape.radius) * 66'(shape.radius);
      in2 = 66'(shape.inner) * 66'(shape.inner);
      cos_ok = ci >= COS_MINUS_ONE && ci < COS_ONE;

      case (shape.kind)
         KIND_SPHERE:  v.shape_ok = shape.radius != 0;
         KIND_CAPSULE: v.shape_ok = shape.radius != 0 && shape.ext_z >= shape.radius;
         KIND_BOX:     v.shape_ok = shape.ext_x != 0 && shape.ext_y != 0 && shape.ext_z != 0;
         KIND_SECTOR:  v.shape_ok = shape.radius != 0 && cos_ok;
         KIND_RING:    v.shape_ok = shape.radius != 0 && shape.inner != 0 &&
                                    shape.inner < shape.radius && cos_ok;
         KIND_LINE:    v.shape_ok = shape.ext_x != 0 && shape.radius != 0;
         default:      v.shape_ok = 1'b0;
      endcase

      v.inside_res = 1'b0;
      if (v.shape_ok) begin
         case (shape.kind)
            KIND_SPHERE: v.inside_res = ax2 + ay2 + az2 <= r2;
            KIND_CAPSULE: begin
               // distance to the core segment along Z
               seg = 32'(shape.ext_z) - 32'(shape.radius);
               dz  = az > seg ? az - seg : 32'd0;
               v.inside_res = ax2 + ay2 + 66'(dz) * 66'(dz) <= r2;
            end
            KIND_BOX: v.inside_res = ax <= 32'(shape.ext_x) && ay <= 32'(shape.ext_y) &&
                                     az <= 32'(shape.ext_z);
            KIND_SECTOR, KIND_RING: begin
               d2 = ax2 + ay2;
               if (az > 32'(shape.ext_z) || d2 > r2)
                  v.inside_res = 1'b0;
               else if (shape.kind == KIND_RING && in2 > d2)
                  v.inside_res = 1'b0;
               else if (c == COS_MINUS_ONE)
                  v.inside_res = 1'b1;
               else if (ax == 0 && ay == 0)
                  v.inside_res = shape.kind == KIND_SECTOR;
               else begin
                  // compare cos^2 of the point's angle with cos^2 of the half angle
                  cmag = ci < 0 ? -ci : ci;
                  lhs  = 100'(ax2) << 32;
                  rhs  = 100'(d2) * 100'(cmag * cmag);
                  if (ci >= 0)
                     v.inside_res = !p.x[31] && rhs <= lhs;
                  else
                     v.inside_res = !p.x[31] || lhs <= rhs;
               end
            end
            KIND_LINE: begin
               dx = p.x[31] ? ax : (ax > 32'(shape.ext_x) ? ax - 32'(shape.ext_x) : 32'd0);
               v.inside_res = 66'(dx) * 66'(dx) + ay2 + az2 <= r2;
            end
            default: v.inside_res = 1'b0;
         endcase
      end
      return v;
   endfunction

   // Idle length for either side: mostly none or short, a few long.
   function automatic int pause_length();
      int unsigned pick;
      if (steady_phase)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      if (pick < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present queued points, predict each one on its transfer.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      point_type sent;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            sent.x = req_ch.point_x;
            sent.y = req_ch.point_y;
            sent.z = req_ch.point_z;
            expected_verdicts.push_back(judge_point(sent));
         end
         // advance only when the current point is gone or none is held
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_points.size() != 0) begin
               sent = pending_points.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.point_x <= sent.x;
               req_ch.point_y <= sent.y;
               req_ch.point_z <= sent.z;
               send_gap = pause_length();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: stall at random, check every result transfer in order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_verdicts.size() == 0) begin
               if (fault_count < 10)
                  $display("unexpected result: inside_res=%0b shape_ok=%0b",
                           rsp_ch.inside_res, rsp_ch.shape_ok);
               fault_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_ch.inside_res !== want.inside_res ||
                   rsp_ch.shape_ok !== want.shape_ok) begin
                  if (fault_count < 10)
                     $display("mismatch: expected inside_res=%0b shape_ok=%0b, got %0b %0b",
                              want.inside_res, want.shape_ok,
                              rsp_ch.inside_res, rsp_ch.shape_ok);
                  fault_count++;
               end
            end
         end
         if (ready_gap > 0) begin
            ready_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            ready_gap = pause_length();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Length of n whole units.
   function automatic logic [LEN_BITS-1:0] unit_len(int n);
      return LEN_BITS'(n * UNIT);
   endfunction

   function automatic cfg_type make_shape(logic [KIND_BITS-1:0] kind, logic [LEN_BITS-1:0] r,
                                          logic [LEN_BITS-1:0] inner, logic [LEN_BITS-1:0] ex,
                                          logic [LEN_BITS-1:0] ey, logic [LEN_BITS-1:0] ez,
                                          logic signed [COS_BITS-1:0] c);
      cfg_type s;
      s.kind     = kind;
      s.radius   = r;
      s.inner    = inner;
      s.ext_x    = ex;
      s.ext_y    = ey;
      s.ext_z    = ez;
      s.cos_half = c;
      return s;
   endfunction

   // Write every register back to back; call only while the core is empty.
   task automatic apply_shape(input cfg_type s);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_KIND;
      csr_wdata <= CSR_DATA_BITS'(s.kind);
      @(posedge clock);
      csr_index <= CSR_RADIUS;
      csr_wdata <= s.radius;
      @(posedge clock);
      csr_index <= CSR_INNER;
      csr_wdata <= s.inner;
      @(posedge clock);
      csr_index <= CSR_EXT_X;
      csr_wdata <= s.ext_x;
      @(posedge clock);
      csr_index <= CSR_EXT_Y;
      csr_wdata <= s.ext_y;
      @(posedge clock);
      csr_index <= CSR_EXT_Z;
      csr_wdata <= s.ext_z;
      @(posedge clock);
      csr_index <= CSR_COS;
      csr_wdata <= CSR_DATA_BITS'(s.cos_half);
      @(posedge clock);
      csr_we <= 1'b0;
      shape = s;
      @(negedge clock);
   endtask

   task automatic queue_point(input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y,
                              input logic signed [COORD_BITS-1:0] z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      pending_points.push_back(p);
      points_queued++;
   endtask

   // Hold until every queued point is transferred and every result is back.
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (pending_points.size() != 0 || req_ch.valid || expected_verdicts.size() != 0);
   endtask

   function automatic logic [LEN_BITS-1:0] rand_len();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return MAX_LEN;
      if (pick < 12)
         return LEN_BITS'($urandom_range(1, 32'h0010_0000));
      return LEN_BITS'($urandom_range(1, 32'h7FFF_FFFF));
   endfunction

   function automatic cfg_type rand_shape();
      cfg_type     s;
      int unsigned pick;
      logic [31:0] sum;
      pick = $urandom_range(0, 15);
      case (pick)
         0, 1:    s.kind = KIND_SPHERE;
         2, 3:    s.kind = KIND_CAPSULE;
         4, 5:    s.kind = KIND_BOX;
         6, 7, 8: s.kind = KIND_SECTOR;
         9, 10, 11: s.kind = KIND_RING;
         12, 13:  s.kind = KIND_LINE;
         14:      s.kind = KIND_BAD_LO;
         default: s.kind = KIND_BAD_HI;
      endcase
      s.radius = rand_len();
      s.inner  = rand_len();
      s.ext_x  = rand_len();
      s.ext_y  = rand_len();
      s.ext_z  = rand_len();
      // keep most capsules and rings well formed so points get past validity
      if (s.kind == KIND_CAPSULE && $urandom_range(0, 4) != 0) begin
         sum = 32'(s.radius) + $urandom_range(0, 32'h0010_0000);
         s.ext_z = sum > 32'(MAX_LEN) ? MAX_LEN : LEN_BITS'(sum);
      end
      if (s.kind == KIND_RING && s.radius > 1 && $urandom_range(0, 4) != 0)
         s.inner = LEN_BITS'($urandom_range(1, 32'(s.radius) - 1));
      pick = $urandom_range(0, 19);
      case (pick)
         0, 1:    s.cos_half = COS_MINUS_ONE;
         2:       s.cos_half = 18'sd65535;
         3:       s.cos_half = COS_ONE;
         4:       s.cos_half = COS_BITS'($urandom_range(65537, 131071));
         5:       s.cos_half = COS_BITS'(-int'($urandom_range(65537, 131072)));
         default: s.cos_half = COS_BITS'(int'($urandom_range(0, 131072)) - 65536);
      endcase
      return s;
   endfunction

   // Coordinate scaled to the shape so that both answers come up often.
   function automatic logic signed [COORD_BITS-1:0] rand_coord(logic [31:0] span);
      int unsigned pick;
      longint      lim;
      logic signed [COORD_BITS-1:0] v;
      if (span > 32'h7FFF_FFFF)
         span = 32'h7FFF_FFFF;
      lim = longint'(span) + longint'(span) / 2 + 1;
      if (lim > 64'h7FFF_FFFF)
         lim = 64'h7FFF_FFFF;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       v = $urandom;
         1:       v = span;
         2:       v = '0;
         default: v = $urandom_range(0, 32'(lim));
      endcase
      if (pick != 0 && $urandom_range(0, 1) == 1)
         v = -v;
      return v;
   endfunction

   function automatic point_type rand_point(cfg_type s);
      logic [31:0] sx, sy, sz;
      point_type   p;
      sx = 32'(s.radius);
      sy = 32'(s.radius);
      sz = 32'(s.radius);
      case (s.kind)
         KIND_BOX: begin
            sx = 32'(s.ext_x);
            sy = 32'(s.ext_y);
            sz = 32'(s.ext_z);
         end
         KIND_CAPSULE, KIND_SECTOR, KIND_RING: sz = 32'(s.ext_z);
         KIND_LINE: sx = 32'(s.ext_x) + 32'(s.radius);
         default: ;
      endcase
      p.x = rand_coord(sx);
      p.y = rand_coord(sy);
      p.z = rand_coord(sz);
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      cfg_type   s;
      point_type p;
      int        n;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_KIND;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      rsp_ch.ready   = 1'b0;
      clock          = 1'b0;
      points_queued  = 0;
      fault_count    = 0;
      steady_phase   = 1'b0;
      shape = make_shape(KIND_SPHERE, '0, '0, '0, '0, '0, COS_MINUS_ONE);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults: zero-radius sphere is not a valid shape.
      queue_point(0, 0, 0);
      wait_quiet();

      // Sphere: boundary on an axis, just past it, most negative corner, boundary off the axes.
      apply_shape(make_shape(KIND_SPHERE, unit_len(10), '0, '0, '0, '0, COS_MINUS_ONE));
      queue_point(10 * UNIT, 0, 0);
      queue_point(10 * UNIT, 1, 0);
      queue_point(MIN_COORD, MIN_COORD, MIN_COORD);
      queue_point(6 * UNIT, -8 * UNIT, 0);
      wait_quiet();

      // Largest radius against the coordinate extremes.
      apply_shape(make_shape(KIND_SPHERE, MAX_LEN, '0, '0, '0, '0, COS_MINUS_ONE));
      queue_point(MIN_COORD, 0, 0);
      queue_point(MAX_COORD, 0, 0);
      wait_quiet();

      // Capsule along Z: cap tip, just below the bottom cap, side wall.
      apply_shape(make_shape(KIND_CAPSULE, unit_len(2), '0, '0, '0, unit_len(5),
                             COS_MINUS_ONE));
      queue_point(0, 0, 5 * UNIT);
      queue_point(0, 0, -5 * UNIT - 1);
      queue_point(2 * UNIT, 0, -3 * UNIT);
      wait_quiet();

      // Box: a corner, and one step past a face.
      apply_shape(make_shape(KIND_BOX, '0, '0, unit_len(3), unit_len(4), unit_len(5),
                             COS_MINUS_ONE));
      queue_point(3 * UNIT, -4 * UNIT, 5 * UNIT);
      queue_point(3 * UNIT + 1, 0, 0);
      wait_quiet();

      // Half-plane sector: point on the axis is inside, edge of the angle.
      apply_shape(make_shape(KIND_SECTOR, unit_len(10), '0, '0, '0, unit_len(1), 18'sd0));
      queue_point(0, 0, 0);
      queue_point(0, 5 * UNIT, 0);
      queue_point(-1, 5 * UNIT, 0);
      wait_quiet();

      // Ring sector, 240 degrees: behind, in front, in the hole, wide angle.
      apply_shape(make_shape(KIND_RING, unit_len(10), unit_len(2), '0, '0, unit_len(1),
                             -18'sd32768));
      queue_point(-5 * UNIT, 0, 0);
      queue_point(5 * UNIT, 0, 0);
      queue_point(UNIT, 0, 0);
      queue_point(-3 * UNIT, 6 * UNIT, 0);
      wait_quiet();

      // Line sweep: behind the start, beside the end, just past the end cap.
      apply_shape(make_shape(KIND_LINE, unit_len(1), '0, unit_len(4), '0, '0, COS_MINUS_ONE));
      queue_point(-UNIT, 0, 0);
      queue_point(5 * UNIT, 0, 0);
      queue_point(5 * UNIT + 1, 0, 0);
      wait_quiet();

      // Invalid shapes: unknown kinds, cosine out of range, short capsule, full ring.
      apply_shape(make_shape(KIND_BAD_LO, unit_len(1), unit_len(1), unit_len(1), unit_len(1),
                             unit_len(1), COS_MINUS_ONE));
      queue_point(0, 0, 0);
      wait_quiet();
      apply_shape(make_shape(KIND_BAD_HI, unit_len(1), unit_len(1), unit_len(1), unit_len(1),
                             unit_len(1), COS_MINUS_ONE));
      queue_point(0, 0, 0);
      wait_quiet();
      apply_shape(make_shape(KIND_SECTOR, unit_len(1), '0, '0, '0, unit_len(1), COS_ONE));
      queue_point(1, 0, 0);
      wait_quiet();
      apply_shape(make_shape(KIND_CAPSULE, unit_len(2), '0, '0, '0, unit_len(1),
                             COS_MINUS_ONE));
      queue_point(0, 0, 0);
      wait_quiet();
      apply_shape(make_shape(KIND_RING, unit_len(2), unit_len(2), '0, '0, unit_len(1),
                             COS_MINUS_ONE));
      queue_point(2 * UNIT, 0, 0);
      wait_quiet();

      // Random shapes, each with a burst of points scaled to its size.
      while (points_queued < TOTAL_POINTS) begin
         s = rand_shape();
         apply_shape(s);
         steady_phase = $urandom_range(0, 4) == 0;
         n = $urandom_range(15, 50);
         repeat (n) begin
            p = rand_point(s);
            queue_point(p.x, p.y, p.z);
         end
         wait_quiet();
      end

      // Drain, then let the pipeline run empty for a few more cycles.
      steady_phase = 1'b0;
      wait_quiet();
      repeat (END_CYCLES) @(posedge clock);
      if (fault_count == 0 && expected_verdicts.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
